[rtl/multilevel_priority_rr_scheduler_assert.svh]
// assertion macros used by the scheduler checker
// no dependencies; include by bare file name
`ifndef MULTILEVEL_PRIORITY_RR_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_PRIORITY_RR_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define MPRS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mprs_pkg.sv]
// shared constants, codes and types of the multilevel priority scheduler
// no dependencies
package mprs_pkg;

  localparam int unsigned Levels     = 3;
  // queues are circular, so the depth must be a power of two
  localparam int unsigned QueueDepth = 256;
  localparam int unsigned StoreDepth = Levels * QueueDepth;
  localparam int unsigned LvlW       = $clog2(Levels);
  localparam int unsigned SlotW      = $clog2(QueueDepth);
  localparam int unsigned AddrW      = LvlW + SlotW;
  localparam int unsigned FillW      = SlotW + 1;
  localparam int unsigned CfgAddrW   = 3;

  localparam logic [1:0]  LevelCountReset = 2'd3;
  localparam logic [15:0] QuantumReset    = 16'd4000;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_TICK   = 2'd1,
    OP_FINISH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_PRIO = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_UNKNOWN  = 2'd3
  } status_e;

  typedef enum logic {
    REG_LEVEL_COUNT = 1'b0,
    REG_QUANTUM     = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PREEMPT,
    S_DISP,
    S_DISP_RD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } sched_state_e;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [31:0] arrival;
    logic [15:0] quantum;
  } entry_t;

endpackage

[rtl/mprs_if.sv]
// valid/ready channels of the scheduler: request items and result items
// no dependencies
interface mprs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] task_id;
  logic [1:0] priority_req;

  modport source (output valid, operation, task_id, priority_req, input ready);
  modport sink (input valid, operation, task_id, priority_req, output ready);
endinterface

interface mprs_out_if;
  logic        valid;
  logic        ready;
  logic        running_valid;
  logic [7:0]  running_task;
  logic [1:0]  running_level;
  logic [15:0] quantum_left;
  logic        finished_valid;
  logic [7:0]  finished_task;
  logic [31:0] turnaround;
  logic [1:0]  status;

  modport source (output valid, running_valid, running_task, running_level, quantum_left,
                  finished_valid, finished_task, turnaround, status, input ready);
  modport sink (input valid, running_valid, running_task, running_level, quantum_left,
                finished_valid, finished_task, turnaround, status, output ready);
endinterface

[rtl/multilevel_priority_rr_scheduler.sv]
// top level of the multilevel priority round-robin scheduler
// depends on mprs_pkg, mprs_if (channels) and mprs_ram (task entry store)
//
// One transaction at a time runs through a small sequencer around an entry store
// with one write and one read port, holding one circular queue per level. A
// transaction is taken only while the sequencer is idle and the result register
// is free or being drained. A tick that expires the slice with room left in its
// level, a finish of the running task, and a submit that preempts the running task
// or finds none running each go on to dispatch the best waiting task. A finish of a
// queued task walks the levels in use through the store read port, reading and
// comparing each entry, then closes the gap by reading and writing back each entry
// behind the match; the single read port of the store sets how long that takes.
// No clearing pass is needed after reset.
module multilevel_priority_rr_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mprs_in_if.sink                        item_i,
  mprs_out_if.source                     result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mprs_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned LvlW  = mprs_pkg::LvlW;
  localparam int unsigned SlotW = mprs_pkg::SlotW;
  localparam int unsigned FillW = mprs_pkg::FillW;
  localparam int unsigned Lvls  = mprs_pkg::Levels;

  // configuration
  logic [1:0]  lvl_cnt_q;
  logic [15:0] quantum_q;

  // sequencer and transaction
  mprs_pkg::sched_state_e st_q, st_d;
  logic [1:0] op_q, op_d;
  logic [7:0] id_q, id_d;
  logic [1:0] prio_q, prio_d;

  // queues
  logic [SlotW-1:0] head_q [Lvls];
  logic [SlotW-1:0] head_d [Lvls];
  logic [FillW-1:0] fill_q [Lvls];
  logic [FillW-1:0] fill_d [Lvls];

  // running task
  logic        cur_valid_q, cur_valid_d;
  logic [7:0]  cur_task_q, cur_task_d;
  logic [1:0]  cur_level_q, cur_level_d;
  logic [15:0] cur_left_q, cur_left_d;
  logic [31:0] cur_arr_q, cur_arr_d;
  logic [31:0] tick_q, tick_d;

  // per-transaction result and walk pointers
  logic             fin_q, fin_d;
  logic [31:0]      turn_q, turn_d;
  logic [1:0]       status_q, status_d;
  logic [1:0]       scan_lvl_q, scan_lvl_d;
  logic [FillW-1:0] scan_pos_q, scan_pos_d;
  logic [LvlW-1:0]  disp_lvl_q, disp_lvl_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic        res_rv_q, res_rv_d;
  logic [7:0]  res_rt_q, res_rt_d;
  logic [1:0]  res_rl_q, res_rl_d;
  logic [15:0] res_ql_q, res_ql_d;
  logic        res_fv_q, res_fv_d;
  logic [7:0]  res_ft_q, res_ft_d;
  logic [31:0] res_ta_q, res_ta_d;
  logic [1:0]  res_st_q, res_st_d;

  // store port
  logic                           mem_we, mem_re;
  logic [mprs_pkg::AddrW-1:0]     mem_waddr, mem_raddr;
  mprs_pkg::entry_t               mem_wdata, mem_rdata;

  // decisions
  logic            in_ready, accept;
  logic [1:0]      liu;
  logic            prio_bad, full_p, full_c, preempt, expire, match_cur;
  logic [LvlW-1:0] pidx, cidx, sidx;
  logic            found;
  logic [LvlW-1:0] best;
  logic            lvls_done, pos_end, shift_end, scan_hit;

  mprs_ram #(
    .Depth (mprs_pkg::StoreDepth),
    .Width ($bits(mprs_pkg::entry_t))
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_cnt_q <= mprs_pkg::LevelCountReset;
      quantum_q <= mprs_pkg::QuantumReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        mprs_pkg::REG_LEVEL_COUNT: lvl_cnt_q <= pwdata[1:0];
        mprs_pkg::REG_QUANTUM:     quantum_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mprs_pkg::REG_LEVEL_COUNT: prdata = {30'd0, lvl_cnt_q};
      mprs_pkg::REG_QUANTUM:     prdata = {16'd0, quantum_q};
      default:                   prdata = '0;
    endcase
  end

  // shared decisions
  assign in_ready    = (st_q == mprs_pkg::S_IDLE) && (!out_valid_q || result_o.ready);
  assign item_i.ready = in_ready;
  assign accept      = item_i.valid && in_ready;

  assign liu = ({2'b00, lvl_cnt_q} > 4'(Lvls)) ? 2'(Lvls) : lvl_cnt_q;

  assign pidx      = LvlW'(prio_q - 2'd1);
  assign cidx      = LvlW'(cur_level_q - 2'd1);
  assign sidx      = scan_lvl_q[LvlW-1:0];
  assign prio_bad  = (prio_q == 2'd0) || (prio_q > liu);
  assign full_p    = fill_q[pidx] == FillW'(mprs_pkg::QueueDepth);
  assign full_c    = fill_q[cidx] == FillW'(mprs_pkg::QueueDepth);
  assign preempt   = cur_valid_q && (prio_q < cur_level_q);
  assign expire    = cur_left_q <= 16'd1;
  assign match_cur = cur_valid_q && (cur_task_q == id_q);
  assign lvls_done = scan_lvl_q >= liu;
  assign pos_end   = scan_pos_q >= fill_q[sidx];
  assign shift_end = (scan_pos_q + FillW'(1)) >= fill_q[sidx];
  assign scan_hit  = mem_rdata.task_id == id_q;

  // best non-empty level in use
  always_comb begin
    found = 1'b0;
    best  = '0;
    for (int l = 0; l < Lvls; l++) begin
      if (!found && (l < int'(liu)) && (fill_q[l] != '0)) begin
        found = 1'b1;
        best  = LvlW'(l);
      end
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      mprs_pkg::S_IDLE: begin
        if (accept) st_d = mprs_pkg::S_EXEC;
      end
      mprs_pkg::S_EXEC: begin
        case (op_q)
          mprs_pkg::OP_SUBMIT: begin
            if (prio_bad || full_p || (preempt && full_c)) st_d = mprs_pkg::S_DONE;
            else if (preempt) st_d = mprs_pkg::S_PREEMPT;
            else if (!cur_valid_q) st_d = mprs_pkg::S_DISP;
            else st_d = mprs_pkg::S_DONE;
          end
          mprs_pkg::OP_TICK: begin
            if (cur_valid_q && expire && !full_c) st_d = mprs_pkg::S_DISP;
            else st_d = mprs_pkg::S_DONE;
          end
          mprs_pkg::OP_FINISH: begin
            st_d = match_cur ? mprs_pkg::S_DISP : mprs_pkg::S_SCAN_RD;
          end
          default: st_d = mprs_pkg::S_DONE;
        endcase
      end
      mprs_pkg::S_PREEMPT: st_d = mprs_pkg::S_DISP;
      mprs_pkg::S_DISP:    st_d = found ? mprs_pkg::S_DISP_RD : mprs_pkg::S_DONE;
      mprs_pkg::S_DISP_RD: st_d = mprs_pkg::S_DONE;
      mprs_pkg::S_SCAN_RD: begin
        if (lvls_done) st_d = mprs_pkg::S_DONE;
        else if (!pos_end) st_d = mprs_pkg::S_SCAN_CMP;
      end
      mprs_pkg::S_SCAN_CMP: begin
        st_d = scan_hit ? mprs_pkg::S_SHIFT_RD : mprs_pkg::S_SCAN_RD;
      end
      mprs_pkg::S_SHIFT_RD: st_d = shift_end ? mprs_pkg::S_DONE : mprs_pkg::S_SHIFT_WR;
      mprs_pkg::S_SHIFT_WR: st_d = mprs_pkg::S_SHIFT_RD;
      mprs_pkg::S_DONE:     st_d = mprs_pkg::S_IDLE;
      default:              st_d = mprs_pkg::S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    op_d        = op_q;
    id_d        = id_q;
    prio_d      = prio_q;
    head_d      = head_q;
    fill_d      = fill_q;
    cur_valid_d = cur_valid_q;
    cur_task_d  = cur_task_q;
    cur_level_d = cur_level_q;
    cur_left_d  = cur_left_q;
    cur_arr_d   = cur_arr_q;
    tick_d      = tick_q;
    fin_d       = fin_q;
    turn_d      = turn_q;
    status_d    = status_q;
    scan_lvl_d  = scan_lvl_q;
    scan_pos_d  = scan_pos_q;
    disp_lvl_d  = disp_lvl_q;
    out_valid_d = out_valid_q && !result_o.ready;
    res_rv_d    = res_rv_q;
    res_rt_d    = res_rt_q;
    res_rl_d    = res_rl_q;
    res_ql_d    = res_ql_q;
    res_fv_d    = res_fv_q;
    res_ft_d    = res_ft_q;
    res_ta_d    = res_ta_q;
    res_st_d    = res_st_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    unique case (st_q)
      mprs_pkg::S_IDLE: begin
        if (accept) begin
          op_d     = item_i.operation;
          id_d     = item_i.task_id;
          prio_d   = item_i.priority_req;
          fin_d    = 1'b0;
          turn_d   = '0;
          status_d = mprs_pkg::STAT_OK;
        end
      end
      mprs_pkg::S_EXEC: begin
        case (op_q)
          mprs_pkg::OP_SUBMIT: begin
            if (prio_bad) begin
              status_d = mprs_pkg::STAT_BAD_PRIO;
            end else if (full_p || (preempt && full_c)) begin
              status_d = mprs_pkg::STAT_FULL;
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = {pidx, SlotW'(head_q[pidx] + fill_q[pidx][SlotW-1:0])};
              mem_wdata    = '{task_id: id_q, arrival: tick_q, quantum: quantum_q};
              fill_d[pidx] = fill_q[pidx] + FillW'(1);
            end
          end
          mprs_pkg::OP_TICK: begin
            tick_d = tick_q + 32'd1;
            if (cur_valid_q) begin
              if (!expire) begin
                cur_left_d = cur_left_q - 16'd1;
              end else if (full_c) begin
                cur_left_d = quantum_q;
              end else begin
                // back to the tail, full slice at next dispatch
                mem_we       = 1'b1;
                mem_waddr    = {cidx, SlotW'(head_q[cidx] + fill_q[cidx][SlotW-1:0])};
                mem_wdata    = '{task_id: cur_task_q, arrival: cur_arr_q, quantum: 16'd0};
                fill_d[cidx] = fill_q[cidx] + FillW'(1);
              end
            end
          end
          mprs_pkg::OP_FINISH: begin
            if (match_cur) begin
              fin_d  = 1'b1;
              turn_d = tick_q - cur_arr_q;
            end else begin
              scan_lvl_d = '0;
              scan_pos_d = '0;
            end
          end
          default: ;
        endcase
      end
      mprs_pkg::S_PREEMPT: begin
        // preempted task returns to the front keeping its slice
        head_d[cidx] = head_q[cidx] - SlotW'(1);
        fill_d[cidx] = fill_q[cidx] + FillW'(1);
        mem_we       = 1'b1;
        mem_waddr    = {cidx, SlotW'(head_q[cidx] - SlotW'(1))};
        mem_wdata    = '{task_id: cur_task_q, arrival: cur_arr_q,
                         quantum: (cur_left_q != 16'd0) ? cur_left_q : 16'd1};
      end
      mprs_pkg::S_DISP: begin
        if (found) begin
          mem_re     = 1'b1;
          mem_raddr  = {best, head_q[best]};
          disp_lvl_d = best;
        end else begin
          cur_valid_d = 1'b0;
          cur_task_d  = '0;
          cur_level_d = '0;
          cur_left_d  = '0;
          cur_arr_d   = '0;
        end
      end
      mprs_pkg::S_DISP_RD: begin
        cur_valid_d        = 1'b1;
        cur_task_d         = mem_rdata.task_id;
        cur_arr_d          = mem_rdata.arrival;
        cur_level_d        = 2'(disp_lvl_q) + 2'd1;
        cur_left_d         = (mem_rdata.quantum != 16'd0) ? mem_rdata.quantum : quantum_q;
        head_d[disp_lvl_q] = head_q[disp_lvl_q] + SlotW'(1);
        fill_d[disp_lvl_q] = fill_q[disp_lvl_q] - FillW'(1);
      end
      mprs_pkg::S_SCAN_RD: begin
        if (lvls_done) begin
          status_d = mprs_pkg::STAT_UNKNOWN;
        end else if (pos_end) begin
          scan_lvl_d = scan_lvl_q + 2'd1;
          scan_pos_d = '0;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = {sidx, SlotW'(head_q[sidx] + scan_pos_q[SlotW-1:0])};
        end
      end
      mprs_pkg::S_SCAN_CMP: begin
        if (scan_hit) begin
          fin_d  = 1'b1;
          turn_d = tick_q - mem_rdata.arrival;
        end else begin
          scan_pos_d = scan_pos_q + FillW'(1);
        end
      end
      mprs_pkg::S_SHIFT_RD: begin
        if (shift_end) begin
          fill_d[sidx] = fill_q[sidx] - FillW'(1);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = {sidx, SlotW'(head_q[sidx] + scan_pos_q[SlotW-1:0] + SlotW'(1))};
        end
      end
      mprs_pkg::S_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = {sidx, SlotW'(head_q[sidx] + scan_pos_q[SlotW-1:0])};
        mem_wdata  = mem_rdata;
        scan_pos_d = scan_pos_q + FillW'(1);
      end
      mprs_pkg::S_DONE: begin
        out_valid_d = 1'b1;
        res_rv_d    = cur_valid_q;
        res_rt_d    = cur_valid_q ? cur_task_q : 8'd0;
        res_rl_d    = cur_valid_q ? cur_level_q : 2'd0;
        res_ql_d    = cur_valid_q ? cur_left_q : 16'd0;
        res_fv_d    = fin_q;
        res_ft_d    = fin_q ? id_q : 8'd0;
        res_ta_d    = turn_q;
        res_st_d    = status_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= mprs_pkg::S_IDLE;
      head_q      <= '{default: '0};
      fill_q      <= '{default: '0};
      cur_valid_q <= 1'b0;
      cur_task_q  <= '0;
      cur_level_q <= '0;
      cur_left_q  <= '0;
      cur_arr_q   <= '0;
      tick_q      <= '0;
      scan_lvl_q  <= '0;
      scan_pos_q  <= '0;
      disp_lvl_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      cur_valid_q <= cur_valid_d;
      cur_task_q  <= cur_task_d;
      cur_level_q <= cur_level_d;
      cur_left_q  <= cur_left_d;
      cur_arr_q   <= cur_arr_d;
      tick_q      <= tick_d;
      scan_lvl_q  <= scan_lvl_d;
      scan_pos_q  <= scan_pos_d;
      disp_lvl_q  <= disp_lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    id_q     <= id_d;
    prio_q   <= prio_d;
    fin_q    <= fin_d;
    turn_q   <= turn_d;
    status_q <= status_d;
    res_rv_q <= res_rv_d;
    res_rt_q <= res_rt_d;
    res_rl_q <= res_rl_d;
    res_ql_q <= res_ql_d;
    res_fv_q <= res_fv_d;
    res_ft_q <= res_ft_d;
    res_ta_q <= res_ta_d;
    res_st_q <= res_st_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.running_valid  = res_rv_q;
  assign result_o.running_task   = res_rt_q;
  assign result_o.running_level  = res_rl_q;
  assign result_o.quantum_left   = res_ql_q;
  assign result_o.finished_valid = res_fv_q;
  assign result_o.finished_task  = res_ft_q;
  assign result_o.turnaround     = res_ta_q;
  assign result_o.status         = res_st_q;

endmodule

[rtl/mprs_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module mprs_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mprs_checker.sv]
// port-level checker of the scheduler, bound to the top level
// depends on multilevel_priority_rr_scheduler_assert.svh, mprs_pkg and the top level
`include "multilevel_priority_rr_scheduler_assert.svh"

module mprs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        running_valid_i,
  input logic [7:0]  running_task_i,
  input logic [1:0]  running_level_i,
  input logic [15:0] quantum_left_i,
  input logic        finished_valid_i,
  input logic [7:0]  finished_task_i,
  input logic [31:0] turnaround_i,
  input logic [1:0]  status_i
);

  // idle scheduler reports all-zero running fields
  `MPRS_ASSERT_IMPL(a_idle_zero, clk_i, rst_ni, out_valid_i && !running_valid_i, running_task_i == 8'd0 && running_level_i == 2'd0 && quantum_left_i == 16'd0, "running fields nonzero with no task dispatched")

  // no retirement reported means zero finish fields
  `MPRS_ASSERT_IMPL(a_nofin_zero, clk_i, rst_ni, out_valid_i && !finished_valid_i, finished_task_i == 8'd0 && turnaround_i == 32'd0, "finish fields nonzero without a retired task")

  // a rejected or unknown transaction never retires a task
  `MPRS_ASSERT_IMPL(a_status_fin, clk_i, rst_ni, out_valid_i && status_i != mprs_pkg::STAT_OK, !finished_valid_i, "task retired on a failing transaction")

  // no new transaction while a result is stalled
  `MPRS_ASSERT_IMPL(a_stall_blocks, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i, "input taken while result stalled")

  // stalled result holds
  `MPRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(running_task_i) && $stable(turnaround_i) && $stable(status_i), "stalled result changed")

endmodule

bind multilevel_priority_rr_scheduler mprs_checker u_mprs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (item_i.ready),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .running_valid_i  (result_o.running_valid),
  .running_task_i   (result_o.running_task),
  .running_level_i  (result_o.running_level),
  .quantum_left_i   (result_o.quantum_left),
  .finished_valid_i (result_o.finished_valid),
  .finished_task_i  (result_o.finished_task),
  .turnaround_i     (result_o.turnaround),
  .status_i         (result_o.status)
);

[tb/multilevel_priority_rr_scheduler_tb.sv]
// self-checking testbench of the multilevel priority round-robin scheduler
// depends on mprs_pkg, mprs_if and the scheduler rtl; holds its own scheduler predictor
`timescale 1ns / 100ps

module multilevel_priority_rr_scheduler_tb;

  localparam int          QDepth     = int'(mprs_pkg::QueueDepth);
  localparam int          CycleLimit = 20_000_000;
  localparam logic [1:0]  OpUnused   = 2'd3;
  localparam logic [2:0]  AddrLevels = 3'(mprs_pkg::REG_LEVEL_COUNT) << 2;
  localparam logic [2:0]  AddrQuant  = 3'(mprs_pkg::REG_QUANTUM) << 2;

  typedef struct {
    logic [7:0]  task_id;
    logic [31:0] arrival;
    logic [15:0] quantum;
  } sched_entry_t;

  typedef struct {
    logic        running_valid;
    logic [7:0]  running_task;
    logic [1:0]  running_level;
    logic [15:0] quantum_left;
    logic        finished_valid;
    logic [7:0]  finished_task;
    logic [31:0] turnaround;
    logic [1:0]  status;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mprs_in_if  item_if ();
  mprs_out_if res_if ();

  multilevel_priority_rr_scheduler u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [1:0]    pred_levels = mprs_pkg::LevelCountReset;
  logic [15:0]   pred_quantum = mprs_pkg::QuantumReset;
  sched_entry_t  level_q[mprs_pkg::Levels][$];
  logic          run_valid = 1'b0;
  logic [7:0]    run_task = '0;
  logic [1:0]    run_level = '0;
  logic [15:0]   run_left = '0;
  logic [31:0]   run_arrival = '0;
  logic [31:0]   tick_cnt = '0;

  sched_result_t expected_results[$];
  int            mismatches = 0;
  int            cycles = 0;
  bit            idle_en = 1'b1;
  int            stall_left = 0;

  function automatic void dispatch_best();
    sched_entry_t e;
    for (int l = 0; l < int'(pred_levels); l++) begin
      if (level_q[l].size() > 0) begin
        e = level_q[l].pop_front();
        run_valid   = 1'b1;
        run_task    = e.task_id;
        run_arrival = e.arrival;
        run_level   = 2'(l + 1);
        run_left    = (e.quantum != 0) ? e.quantum : pred_quantum;
        return;
      end
    end
    run_valid = 1'b0; run_task = '0; run_level = '0; run_left = '0; run_arrival = '0;
  endfunction

  function automatic sched_result_t schedule_item(logic [1:0] op, logic [7:0] id,
                                                  logic [1:0] prio);
    sched_result_t r;
    bit preempt;
    bit found;
    r = '{default: '0};
    r.status = mprs_pkg::STAT_OK;
    found = 1'b0;
    if (op == mprs_pkg::OP_SUBMIT) begin
      preempt = run_valid && (prio < run_level);
      if (prio < 1 || prio > pred_levels) begin
        r.status = mprs_pkg::STAT_BAD_PRIO;
      end else if (level_q[prio-1].size() >= QDepth ||
                   (preempt && level_q[run_level-1].size() >= QDepth)) begin
        r.status = mprs_pkg::STAT_FULL;
      end else begin
        level_q[prio-1].push_back('{id, tick_cnt, pred_quantum});
        if (preempt) begin
          level_q[run_level-1].push_front('{run_task, run_arrival,
                                           (run_left != 0) ? run_left : 16'd1});
          dispatch_best();
        end else if (!run_valid) begin
          dispatch_best();
        end
      end
    end else if (op == mprs_pkg::OP_TICK) begin
      tick_cnt++;
      if (run_valid) begin
        if (run_left <= 1) begin
          if (level_q[run_level-1].size() >= QDepth) begin
            run_left = pred_quantum;
          end else begin
            level_q[run_level-1].push_back('{run_task, run_arrival, 16'd0});
            dispatch_best();
          end
        end else begin
          run_left--;
        end
      end
    end else if (op == mprs_pkg::OP_FINISH) begin
      if (run_valid && run_task == id) begin
        found = 1'b1;
        r.turnaround = tick_cnt - run_arrival;
        dispatch_best();
      end else begin
        for (int l = 0; l < int'(pred_levels) && !found; l++) begin
          for (int i = 0; i < level_q[l].size(); i++) begin
            if (level_q[l][i].task_id == id) begin
              found = 1'b1;
              r.turnaround = tick_cnt - level_q[l][i].arrival;
              level_q[l].delete(i);
              break;
            end
          end
        end
        if (!found) r.status = mprs_pkg::STAT_UNKNOWN;
      end
    end
    r.finished_valid = found;
    r.finished_task  = found ? id : 8'd0;
    r.running_valid  = run_valid;
    r.running_task   = run_valid ? run_task : 8'd0;
    r.running_level  = run_valid ? run_level : 2'd0;
    r.quantum_left   = run_valid ? run_left : 16'd0;
    return r;
  endfunction

  // sender: ends at a falling edge with valid still high
  task automatic send_item(logic [1:0] op, logic [7:0] id, logic [1:0] prio);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    item_if.valid        <= 1'b1;
    item_if.operation    <= op;
    item_if.task_id      <= id;
    item_if.priority_req <= prio;
    do @(posedge clk_i); while (!item_if.ready);
    expected_results.push_back(schedule_item(op, id, prio));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    wait_drained();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrLevels) pred_levels = data[1:0];
    else pred_quantum = data[15:0];
  endtask

  task automatic set_config(logic [1:0] levels, logic [15:0] quantum);
    write_reg(AddrLevels, {$urandom} & 32'hffff_fffc | levels);
    write_reg(AddrQuant, {$urandom} & 32'hffff_0000 | quantum);
  endtask

  task automatic test_basic_ops();
    send_item(mprs_pkg::OP_TICK, 8'd0, 2'd1);       // idle tick, nothing to dispatch
    send_item(mprs_pkg::OP_FINISH, 8'd255, 2'd0);   // unknown task
    send_item(OpUnused, 8'd170, 2'd3);
    send_item(mprs_pkg::OP_SUBMIT, 8'd1, 2'd0);     // bad priority
    send_item(mprs_pkg::OP_SUBMIT, 8'd10, 2'd3);
    send_item(mprs_pkg::OP_SUBMIT, 8'd11, 2'd3);
    send_item(mprs_pkg::OP_TICK, 8'd85, 2'd2);
    send_item(mprs_pkg::OP_SUBMIT, 8'd20, 2'd2);    // preempts level 3
    send_item(mprs_pkg::OP_SUBMIT, 8'd30, 2'd1);    // preempts level 2
    send_item(mprs_pkg::OP_SUBMIT, 8'd30, 2'd1);    // repeated id
    send_item(mprs_pkg::OP_TICK, 8'd0, 2'd0);
    send_item(mprs_pkg::OP_FINISH, 8'd30, 2'd0);    // running one retires first
    send_item(mprs_pkg::OP_FINISH, 8'd11, 2'd0);    // queued
    send_item(mprs_pkg::OP_FINISH, 8'd30, 2'd0);
    send_item(mprs_pkg::OP_FINISH, 8'd20, 2'd0);
    send_item(mprs_pkg::OP_FINISH, 8'd10, 2'd0);
  endtask

  task automatic test_slice_expiry();
    set_config(2'd3, 16'd2);
    send_item(mprs_pkg::OP_SUBMIT, 8'd1, 2'd2);
    send_item(mprs_pkg::OP_SUBMIT, 8'd2, 2'd2);
    repeat (5) send_item(mprs_pkg::OP_TICK, 8'd0, 2'd0);
    send_item(mprs_pkg::OP_SUBMIT, 8'd3, 2'd1);     // preempt keeps remaining slice
    send_item(mprs_pkg::OP_FINISH, 8'd3, 2'd0);
    set_config(2'd3, 16'd0);                        // zero slice
    send_item(mprs_pkg::OP_SUBMIT, 8'd4, 2'd2);
    repeat (3) send_item(mprs_pkg::OP_TICK, 8'd0, 2'd0);
    send_item(mprs_pkg::OP_SUBMIT, 8'd5, 2'd1);
    send_item(mprs_pkg::OP_TICK, 8'd0, 2'd0);
    for (int i = 1; i <= 5; i++) send_item(mprs_pkg::OP_FINISH, 8'(i), 2'd0);
  endtask

  task automatic test_level_limit();
    set_config(2'd3, 16'd3);
    send_item(mprs_pkg::OP_SUBMIT, 8'd40, 2'd3);
    send_item(mprs_pkg::OP_SUBMIT, 8'd41, 2'd3);
    set_config(2'd1, 16'd65535);
    send_item(mprs_pkg::OP_SUBMIT, 8'd42, 2'd2);    // above levels in use
    send_item(mprs_pkg::OP_FINISH, 8'd41, 2'd0);    // stranded, not found
    repeat (4) send_item(mprs_pkg::OP_TICK, 8'd0, 2'd0);
    send_item(mprs_pkg::OP_FINISH, 8'd40, 2'd0);
    send_item(mprs_pkg::OP_TICK, 8'd0, 2'd0);       // idle tick does not dispatch
    set_config(2'd0, 16'd5);
    send_item(mprs_pkg::OP_SUBMIT, 8'd43, 2'd1);
    set_config(2'd3, 16'd5);
    send_item(mprs_pkg::OP_SUBMIT, 8'd44, 2'd1);
    send_item(mprs_pkg::OP_FINISH, 8'd44, 2'd0);
    send_item(mprs_pkg::OP_FINISH, 8'd41, 2'd0);
  endtask

  task automatic test_full_queue();
    set_config(2'd3, 16'd2);
    for (int i = 0; i <= QDepth; i++) send_item(mprs_pkg::OP_SUBMIT, 8'(i), 2'd3);
    send_item(mprs_pkg::OP_SUBMIT, 8'd200, 2'd3);   // level full
    send_item(mprs_pkg::OP_SUBMIT, 8'd201, 2'd1);   // preempt blocked by full level
    repeat (3) send_item(mprs_pkg::OP_TICK, 8'd0, 2'd0);  // expiry with full level reloads
    wait_drained();                        // sender holds until all results are in
    while (run_valid) send_item(mprs_pkg::OP_FINISH, run_task, 2'd0);
  endtask

  task automatic test_random(int count);
    logic [1:0] op;
    logic [7:0] id;
    int pick, fill, l;
    for (int n = 0; n < count; n++) begin
      fill = level_q[0].size() + level_q[1].size() + level_q[2].size();
      pick = $urandom_range(0, 99);
      if (fill > 24 && pick < 40) pick += 60;
      op = (pick < 40) ? mprs_pkg::OP_SUBMIT : (pick < 75) ? mprs_pkg::OP_TICK :
           (pick < 96) ? mprs_pkg::OP_FINISH : OpUnused;
      id = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      if (op == mprs_pkg::OP_FINISH && $urandom_range(0, 3) != 0) begin
        l = $urandom_range(0, 2);
        if (level_q[l].size() > 0)
          id = level_q[l][$urandom_range(0, level_q[l].size() - 1)].task_id;
        else if (run_valid)
          id = run_task;
      end
      send_item(op, id, ($urandom_range(0, 9) == 0) ? 2'($urandom) :
                        2'($urandom_range(1, 3)));
    end
  endtask

  // result side: random stall bursts, sampled at the rising edge
  always @(negedge clk_i) begin
    if (idle_en && stall_left == 0 && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 3);
    if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sched_result_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with none expected");
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        if (res_if.running_valid !== e.running_valid) begin
          $error("running_valid: expected %0d actual %0d", e.running_valid,
                 res_if.running_valid); mismatches++; end
        if (res_if.running_task !== e.running_task) begin
          $error("running_task: expected %0d actual %0d", e.running_task,
                 res_if.running_task); mismatches++; end
        if (res_if.running_level !== e.running_level) begin
          $error("running_level: expected %0d actual %0d", e.running_level,
                 res_if.running_level); mismatches++; end
        if (res_if.quantum_left !== e.quantum_left) begin
          $error("quantum_left: expected %0d actual %0d", e.quantum_left,
                 res_if.quantum_left); mismatches++; end
        if (res_if.finished_valid !== e.finished_valid) begin
          $error("finished_valid: expected %0d actual %0d", e.finished_valid,
                 res_if.finished_valid); mismatches++; end
        if (res_if.finished_task !== e.finished_task) begin
          $error("finished_task: expected %0d actual %0d", e.finished_task,
                 res_if.finished_task); mismatches++; end
        if (res_if.turnaround !== e.turnaround) begin
          $error("turnaround: expected %0d actual %0d", e.turnaround,
                 res_if.turnaround); mismatches++; end
        if (res_if.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, res_if.status);
          mismatches++; end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    item_if.valid = 1'b0;
    item_if.operation = mprs_pkg::OP_SUBMIT;
    item_if.task_id = '0;
    item_if.priority_req = '0;
    res_if.ready = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_basic_ops();
    test_slice_expiry();
    test_level_limit();
    test_full_queue();
    set_config(2'd3, 16'd3);
    test_random(60);
    wait_drained();                        // sender holds until all results are in
    set_config(2'd2, 16'd1);
    test_random(40);
    set_config(2'd3, 16'd65535);
    test_random(30);
    set_config(2'd3, 16'd0);
    test_random(30);
    set_config(2'd3, 16'($urandom_range(2, 6)));
    idle_en = 1'b0;
    test_random(40);
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
